/* hw/rtl/lltd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lltd_pkg
// Shared types, codes and defaults for the least-loaded task dispatcher.
// ----------------------------------------------------------------------------
package lltd_pkg;

   // default sizing
   localparam int NUM_WORKERS_DEF      = 16;
   localparam int SLOTS_PER_WORKER_DEF = 5;
   localparam int QUEUE_DEPTH_DEF      = 64;

   // fixed field widths
   localparam int KIND_W   = 2;
   localparam int TASK_W   = 16;
   localparam int WORKER_W = 4;
   localparam int LOAD_W   = 10;
   localparam int STAT_W   = 2;
   localparam int SLOT_W   = 3;
   localparam int REC_W    = 3;
   localparam int LEVEL_W  = 7;
   localparam int LIMIT_W  = 11;
   localparam int WEIGHT_W = 4;
   localparam int LF_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_SUBMIT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECOVER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd3;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NO_WORKER = 2'd3;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_WEIGHT = 1'd1;
   localparam logic [LIMIT_W-1:0]   LOAD_LIMIT_RST  = 11'd1000;
   localparam logic [WEIGHT_W-1:0]  TASK_WEIGHT_RST = 4'd2;

   // queue control
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   // slot store control
   typedef struct packed {
      logic wr;
      logic clr;
      logic rd;
   } slot_ctl_type;

endpackage

/* hw/rtl/lltd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lltd_fifo
// Task id queue: one memory, write at tail, registered read at head.
// ----------------------------------------------------------------------------
module lltd_fifo #(
   parameter int QUEUE_DEPTH = lltd_pkg::QUEUE_DEPTH_DEF,
   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lltd_pkg::fifo_ctl_type      ctl,
   input  logic [lltd_pkg::TASK_W-1:0] wr_data,
   output logic [lltd_pkg::TASK_W-1:0] rd_data,
   output logic [QC_W-1:0]             level
);
   import lltd_pkg::*;

   logic [TASK_W-1:0] mem [QUEUE_DEPTH];
   logic [TASK_W-1:0] rd_data_ff;
   logic [QA_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [QC_W-1:0]   count_ff, count_in;

   // pointer and count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in  = (tail_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_in + 1'b1;
      end
      if (ctl.pop) begin
         head_in  = (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rd_data = rd_data_ff;
   assign level   = count_ff;

endmodule

/* hw/rtl/lltd_slots.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lltd_slots
// Per-worker slot table: valid bits in flops, task ids in a memory.
// ----------------------------------------------------------------------------
module lltd_slots #(
   parameter int NUM_WORKERS      = lltd_pkg::NUM_WORKERS_DEF,
   parameter int SLOTS_PER_WORKER = lltd_pkg::SLOTS_PER_WORKER_DEF,
   localparam int ENTRIES = NUM_WORKERS * SLOTS_PER_WORKER,
   localparam int SA_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int WI_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lltd_pkg::slot_ctl_type      ctl,
   input  logic [SA_W-1:0]             addr,
   input  logic [lltd_pkg::TASK_W-1:0] wr_data,
   input  logic [WI_W-1:0]             row_sel,
   output logic [SLOTS_PER_WORKER-1:0] row_valid,
   output logic [lltd_pkg::TASK_W-1:0] rd_data
);
   import lltd_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [TASK_W-1:0]  mem [ENTRIES];
   logic [TASK_W-1:0]  rd_data_ff;

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr) begin
         valid_ff[addr] <= 1'b1;
      end else if (ctl.clr) begin
         valid_ff[addr] <= 1'b0;
      end
   end

   // id storage
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign row_valid = valid_ff[int'(row_sel) * SLOTS_PER_WORKER +: SLOTS_PER_WORKER];
   assign rd_data   = rd_data_ff;

endmodule

/* hw/rtl/least_loaded_task_dispatcher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher_unit
// Task queue feeding per-worker slot tables, least-loaded worker selection.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel carrying one command beat: submit, dispatch
//   head, recover worker or set worker status. Every beat yields exactly one
//   rsp_* beat. The block works on one command at a time; req_ready is high
//   only while the sequencer is idle.
//   Sequence per command: submit and status pass their own work state;
//   dispatch pops the queue, does one load-factor compare per worker on a
//   single shared comparator, then a slot placement; recover walks the
//   worker's slots, and each occupied slot is a slot-memory read then a
//   queue push. An empty-queue dispatch or a recover of an out-of-range
//   worker goes straight to the final state.
//   The response sits in an output register; while a stalled receiver holds
//   that beat the next command is still taken and worked on, but it waits
//   in its final state with req_ready low until the register drains.
//   csr_* writes load_limit (index 0) and task_weight (index 1); the user
//   must write them only while the block is idle, which it does not enforce.
//   Synchronous reset empties the queue, frees all slots, marks every worker
//   dead with zero load and count, and restores the register defaults.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher_unit #(
   parameter int NUM_WORKERS      = lltd_pkg::NUM_WORKERS_DEF,
   parameter int SLOTS_PER_WORKER = lltd_pkg::SLOTS_PER_WORKER_DEF,
   parameter int QUEUE_DEPTH      = lltd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lltd_pkg::KIND_W-1:0]    req_kind,
   input  logic [lltd_pkg::TASK_W-1:0]    req_task_id,
   input  logic [lltd_pkg::WORKER_W-1:0]  req_worker,
   input  logic                           req_alive,
   input  logic [lltd_pkg::LOAD_W-1:0]    req_load,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lltd_pkg::STAT_W-1:0]    rsp_status,
   output logic [lltd_pkg::TASK_W-1:0]    rsp_out_task,
   output logic [lltd_pkg::WORKER_W-1:0]  rsp_out_worker,
   output logic [lltd_pkg::SLOT_W-1:0]    rsp_out_slot,
   output logic [lltd_pkg::REC_W-1:0]     rsp_recovered_count,
   output logic [lltd_pkg::LEVEL_W-1:0]   rsp_queue_level,
   // register writes
   input  logic                           csr_we,
   input  logic [lltd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lltd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import lltd_pkg::*;

   localparam int ENTRIES = NUM_WORKERS * SLOTS_PER_WORKER;
   localparam int SA_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WI_W  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int SI_W  = (SLOTS_PER_WORKER > 1) ? $clog2(SLOTS_PER_WORKER) : 1;
   localparam int CNT_W = $clog2(SLOTS_PER_WORKER + 1);
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SUBMIT = 4'd1;
   localparam logic [3:0] ST_STATUS = 4'd2;
   localparam logic [3:0] ST_POP    = 4'd3;
   localparam logic [3:0] ST_SCAN   = 4'd4;
   localparam logic [3:0] ST_PLACE  = 4'd5;
   localparam logic [3:0] ST_RREAD  = 4'd6;
   localparam logic [3:0] ST_RPUSH  = 4'd7;
   localparam logic [3:0] ST_RDONE  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [TASK_W-1:0]   tid_ff;
   logic [WORKER_W-1:0] w_ff;
   logic                alv_ff;
   logic [LOAD_W-1:0]   ld_ff;
   logic [LIMIT_W-1:0]  load_limit_ff;
   logic [WEIGHT_W-1:0] task_weight_ff;

   logic [WI_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [LF_W-1:0]     best_ff, best_in;
   logic                found_ff, found_in;
   logic [WI_W-1:0]     chosen_ff, chosen_in;
   logic [SI_W-1:0]     rs_ff, rs_in;

   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [TASK_W-1:0]   res_task_ff, res_task_in;
   logic [WORKER_W-1:0] res_worker_ff, res_worker_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [REC_W-1:0]    res_rec_ff, res_rec_in;

   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic [TASK_W-1:0]   rsp_task_ff;
   logic [WORKER_W-1:0] rsp_worker_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [REC_W-1:0]    rsp_rec_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;

   logic [CNT_W-1:0]    cnt_ff   [NUM_WORKERS];
   logic                alive_ff [NUM_WORKERS];
   logic [LOAD_W-1:0]   load_ff  [NUM_WORKERS];

   fifo_ctl_type          fifo_ctl;
   logic [TASK_W-1:0]     fifo_wr_data, fifo_rd_data;
   logic [QC_W-1:0]       fifo_level;
   slot_ctl_type          slot_ctl;
   logic [SA_W-1:0]       slot_addr;
   logic [WI_W-1:0]       row_sel;
   logic [SI_W-1:0]       slot_sel;
   logic [SLOTS_PER_WORKER-1:0] row_valid;
   logic [TASK_W-1:0]     slot_rd_data;

   logic                  req_beat, rsp_load;
   logic [WI_W-1:0]       w_idx;
   logic                  w_ok;
   logic                  q_full;
   logic [LF_W-1:0]       lf;
   logic                  qualify;
   logic                  free_any;
   logic [SI_W-1:0]       free_idx;
   logic                  rs_last;

   assign req_beat = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign w_idx = WI_W'(w_ff);
   assign w_ok = int'(w_ff) < NUM_WORKERS;
   assign q_full = (fifo_level == QC_W'(QUEUE_DEPTH));
   assign rs_last = (rs_ff == SI_W'(SLOTS_PER_WORKER - 1));
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // shared load-factor unit for the worker at the scan index
   always_comb begin
      lf = LF_W'(load_ff[scan_idx_ff])
           + LF_W'(task_weight_ff) * LF_W'(cnt_ff[scan_idx_ff]);
      qualify = alive_ff[scan_idx_ff]
                && (cnt_ff[scan_idx_ff] < CNT_W'(SLOTS_PER_WORKER))
                && (lf < best_ff);
   end

   // slot table row and address select
   assign row_sel  = (state_ff == ST_PLACE) ? chosen_ff : w_idx;
   assign slot_sel = (state_ff == ST_PLACE) ? free_idx : rs_ff;
   assign slot_addr = SA_W'(int'(row_sel) * SLOTS_PER_WORKER + int'(slot_sel));

   // first free slot of the selected row
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS_PER_WORKER - 1; i >= 0; i--) begin
         if (!row_valid[i]) begin
            free_any = 1'b1;
            free_idx = SI_W'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      rs_in         = rs_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      res_worker_in = res_worker_ff;
      res_slot_in   = res_slot_ff;
      res_rec_in    = res_rec_ff;
      fifo_ctl      = '0;
      fifo_wr_data  = res_task_ff;
      slot_ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               res_status_in = STAT_OK;
               res_task_in   = '0;
               res_worker_in = '0;
               res_slot_in   = '0;
               res_rec_in    = '0;
               rs_in         = '0;
               unique case (req_kind)
                  KIND_SUBMIT: state_in = ST_SUBMIT;
                  KIND_DISPATCH: begin
                     if (fifo_level == '0) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  KIND_RECOVER: begin
                     state_in = (int'(req_worker) < NUM_WORKERS) ? ST_RREAD : ST_DONE;
                  end
                  KIND_STATUS: state_in = ST_STATUS;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SUBMIT: begin
            res_task_in  = tid_ff;
            fifo_wr_data = tid_ff;
            if (q_full) begin
               res_status_in = STAT_FULL;
            end else begin
               fifo_ctl.push = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_STATUS: begin
            state_in = ST_DONE;
         end
         ST_POP: begin
            fifo_ctl.pop = 1'b1;
            scan_idx_in  = '0;
            best_in      = LF_W'(load_limit_ff);
            found_in     = 1'b0;
            chosen_in    = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_idx_ff == '0) begin
               res_task_in = fifo_rd_data;
            end
            if (qualify) begin
               best_in   = lf;
               found_in  = 1'b1;
               chosen_in = scan_idx_ff;
            end
            if (scan_idx_ff == WI_W'(NUM_WORKERS - 1)) begin
               state_in = ST_PLACE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_PLACE: begin
            if (found_ff && free_any) begin
               slot_ctl.wr   = 1'b1;
               res_worker_in = WORKER_W'(chosen_ff);
               res_slot_in   = SLOT_W'(free_idx);
            end else begin
               fifo_ctl.push = 1'b1;
               res_status_in = STAT_NO_WORKER;
            end
            state_in = ST_DONE;
         end
         ST_RREAD: begin
            if (row_valid[rs_ff]) begin
               slot_ctl.rd = 1'b1;
               state_in    = ST_RPUSH;
            end else if (rs_last) begin
               state_in = ST_RDONE;
            end else begin
               rs_in = rs_ff + 1'b1;
            end
         end
         ST_RPUSH: begin
            fifo_wr_data = slot_rd_data;
            slot_ctl.clr = 1'b1;
            if (q_full) begin
               res_status_in = STAT_FULL;
            end else begin
               fifo_ctl.push = 1'b1;
               res_rec_in    = res_rec_ff + 1'b1;
            end
            if (rs_last) begin
               state_in = ST_RDONE;
            end else begin
               rs_in    = rs_ff + 1'b1;
               state_in = ST_RREAD;
            end
         end
         ST_RDONE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      best_ff       <= best_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      rs_ff         <= rs_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      res_worker_ff <= res_worker_in;
      res_slot_ff   <= res_slot_in;
      res_rec_ff    <= res_rec_in;
      if (req_beat) begin
         tid_ff  <= req_task_id;
         w_ff    <= req_worker;
         alv_ff  <= req_alive;
         ld_ff   <= req_load;
      end
   end

   // worker tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORKERS; i++) begin
            cnt_ff[i]   <= '0;
            alive_ff[i] <= 1'b0;
            load_ff[i]  <= '0;
         end
      end else begin
         if (state_ff == ST_STATUS && w_ok) begin
            alive_ff[w_idx] <= alv_ff;
            load_ff[w_idx]  <= ld_ff;
         end
         if (state_ff == ST_RDONE) begin
            cnt_ff[w_idx] <= '0;
         end
         if (slot_ctl.wr) begin
            cnt_ff[chosen_ff] <= cnt_ff[chosen_ff] + 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff  <= LOAD_LIMIT_RST;
         task_weight_ff <= TASK_WEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOAD_LIMIT:  load_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_TASK_WEIGHT: task_weight_ff <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_task_ff   <= res_task_ff;
         rsp_worker_ff <= res_worker_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_rec_ff    <= res_rec_ff;
         rsp_level_ff  <= LEVEL_W'(fifo_level);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_task        = rsp_task_ff;
   assign rsp_out_worker      = rsp_worker_ff;
   assign rsp_out_slot        = rsp_slot_ff;
   assign rsp_recovered_count = rsp_rec_ff;
   assign rsp_queue_level     = rsp_level_ff;

   lltd_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .wr_data (fifo_wr_data),
      .rd_data (fifo_rd_data),
      .level   (fifo_level)
   );

   lltd_slots #(
      .NUM_WORKERS      (NUM_WORKERS),
      .SLOTS_PER_WORKER (SLOTS_PER_WORKER)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .ctl       (slot_ctl),
      .addr      (slot_addr),
      .wr_data   (res_task_ff),
      .row_sel   (row_sel),
      .row_valid (row_valid),
      .rd_data   (slot_rd_data)
   );

   // queue never over- or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_ctl.push |-> !q_full)
      else $error("push into full task queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_ctl.pop |-> (fifo_level != '0))
      else $error("pop from empty task queue");

   // placement only into a worker below its slot limit
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      slot_ctl.wr |-> (cnt_ff[chosen_ff] < CNT_W'(SLOTS_PER_WORKER)))
      else $error("slot placement on a full worker");

   // an accepted command always leaves idle
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("sequencer stayed idle after a command beat");

endmodule

/* tb/sv/least_loaded_task_dispatcher_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher_unit_test
// Self-checking bench for the least-loaded task dispatcher. A queue-fed
// driver sends submit, dispatch, recover and status commands. The monitor
// mirrors the task queue, the slot tables and the worker state to predict
// every response beat and compares each field. Register settings change
// between phases while the block is idle. Both sides stall at random.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher_unit_test;
   import lltd_pkg::*;

   localparam int NW        = NUM_WORKERS_DEF;
   localparam int NS        = SLOTS_PER_WORKER_DEF;
   localparam int QD        = QUEUE_DEPTH_DEF;
   localparam int MAX_CYC   = 2000000;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [TASK_W-1:0]   task_id;
      logic [WORKER_W-1:0] worker;
      logic                alive;
      logic [LOAD_W-1:0]   load;
   } cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic [TASK_W-1:0]   out_task;
      logic [WORKER_W-1:0] out_worker;
      logic [SLOT_W-1:0]   out_slot;
      logic [REC_W-1:0]    rec_cnt;
      logic [LEVEL_W-1:0]  level;
   } rsp_type;

   logic clock, reset;
   logic req_valid, req_ready, req_alive;
   logic [KIND_W-1:0]   req_kind;
   logic [TASK_W-1:0]   req_task_id;
   logic [WORKER_W-1:0] req_worker;
   logic [LOAD_W-1:0]   req_load;
   logic rsp_valid, rsp_ready;
   logic [STAT_W-1:0]   rsp_status;
   logic [TASK_W-1:0]   rsp_out_task;
   logic [WORKER_W-1:0] rsp_out_worker;
   logic [SLOT_W-1:0]   rsp_out_slot;
   logic [REC_W-1:0]    rsp_recovered_count;
   logic [LEVEL_W-1:0]  rsp_queue_level;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   least_loaded_task_dispatcher_unit u_top (.*);

   // stimulus and expectation stores
   cmd_type pend_q[$];
   rsp_type rsp_expect_q[$];
   int err_cnt = 0;
   int snd_idle_pct = 0, rcv_idle_pct = 0;
   int hold_seq = 0;
   bit req_taken = 0;
   int n_cmd = 0, n_placed = 0, n_requeue = 0, n_drop = 0, n_recov = 0, n_empty = 0;

   // mirror of the dispatcher state
   logic [TASK_W-1:0]  m_fifo [QD];
   int                 m_head, m_tail, m_count;
   bit                 m_slot_vld [NW*NS];
   logic [TASK_W-1:0]  m_slot_id [NW*NS];
   int                 m_wcount [NW];
   bit                 m_alive [NW];
   int                 m_load [NW];
   int                 m_limit, m_weight;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic bit mirror_enqueue(logic [TASK_W-1:0] id);
      if (m_count >= QD) return 0;
      m_fifo[m_tail] = id;
      m_tail = (m_tail + 1) % QD;
      m_count++;
      return 1;
   endfunction

   // compute the response to one command and advance the mirror
   function automatic rsp_type dispatch_predict(cmd_type c);
      rsp_type r;
      int best, chosen, slot, lf, k, w;
      logic [TASK_W-1:0] id;
      r = '0;
      w = c.worker;
      case (c.kind)
         KIND_SUBMIT: begin
            r.out_task = c.task_id;
            if (!mirror_enqueue(c.task_id)) r.status = STAT_FULL;
         end
         KIND_DISPATCH: begin
            if (m_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               id = m_fifo[m_head];
               m_head = (m_head + 1) % QD;
               m_count--;
               r.out_task = id;
               best = m_limit;
               chosen = -1;
               slot = -1;
               for (int i = 0; i < NW; i++) begin
                  if (!m_alive[i] || m_wcount[i] >= NS) continue;
                  lf = m_load[i] + m_weight * m_wcount[i];
                  if (lf < best) begin
                     best = lf;
                     chosen = i;
                  end
               end
               if (chosen >= 0)
                  for (int s = NS - 1; s >= 0; s--)
                     if (!m_slot_vld[chosen*NS+s]) slot = s;
               if (chosen >= 0 && slot >= 0) begin
                  k = chosen*NS + slot;
                  m_slot_vld[k] = 1;
                  m_slot_id[k] = id;
                  m_wcount[chosen]++;
                  r.out_worker = chosen;
                  r.out_slot = slot;
               end else begin
                  void'(mirror_enqueue(id));
                  r.status = STAT_NO_WORKER;
               end
            end
         end
         KIND_RECOVER: begin
            if (w < NW) begin
               for (int s = 0; s < NS; s++) begin
                  k = w*NS + s;
                  if (m_slot_vld[k]) begin
                     if (mirror_enqueue(m_slot_id[k])) r.rec_cnt++;
                     else r.status = STAT_FULL;
                     m_slot_vld[k] = 0;
                     m_slot_id[k] = '0;
                  end
               end
               m_wcount[w] = 0;
            end
         end
         default: begin
            if (w < NW) begin
               m_alive[w] = c.alive;
               m_load[w] = c.load;
            end
         end
      endcase
      r.level = m_count;
      return r;
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   // monitor: predict on accepted command beats, check response beats
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         req_taken = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expect_q.size() == 0) begin
               $error("response beat with nothing expected");
               err_cnt++;
            end else begin
               e = rsp_expect_q.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("out_task", e.out_task, rsp_out_task);
               check_field("out_worker", e.out_worker, rsp_out_worker);
               check_field("out_slot", e.out_slot, rsp_out_slot);
               check_field("recovered_count", e.rec_cnt, rsp_recovered_count);
               check_field("queue_level", e.level, rsp_queue_level);
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            e = dispatch_predict({req_kind, req_task_id, req_worker, req_alive, req_load});
            rsp_expect_q.push_back(e);
            n_cmd++;
            if (req_kind == KIND_DISPATCH && e.status == STAT_OK) n_placed++;
            if (e.status == STAT_NO_WORKER) n_requeue++;
            if (e.status == STAT_EMPTY) n_empty++;
            if (e.status == STAT_FULL) n_drop++;
            n_recov += e.rec_cnt;
         end
      end
   end

   // command driver
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1;
      end else if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
         c = pend_q.pop_front();
         req_kind <= c.kind;
         req_task_id <= c.task_id;
         req_worker <= c.worker;
         req_alive <= c.alive;
         req_load <= c.load;
         req_valid <= 1;
      end else begin
         req_valid <= 0;
      end
   end

   // response sink with random stalls and a long hold-off on request
   int hold_cnt = 0, hold_seen = 0;
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // run limit
   int cyc = 0;
   always @(posedge clock) begin
      cyc++;
      if (cyc >= MAX_CYC) begin
         $display("least_loaded_task_dispatcher_unit_test: done, errors");
         $finish;
      end
   end

   task automatic add_cmd(logic [KIND_W-1:0] k, int tid, int w, bit a, int ld);
      cmd_type c;
      c.kind = k;
      c.task_id = tid;
      c.worker = w;
      c.alive = a;
      c.load = ld;
      pend_q.push_back(c);
   endtask

   // random commands; weights pick the mix of kinds
   task automatic add_random(int n, int w_sub, int w_dis, int w_rec);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < w_sub)
            add_cmd(KIND_SUBMIT, $urandom, $urandom, $urandom, $urandom);
         else if (r < w_sub + w_dis)
            add_cmd(KIND_DISPATCH, $urandom, $urandom, $urandom, $urandom);
         else if (r < w_sub + w_dis + w_rec)
            add_cmd(KIND_RECOVER, $urandom, $urandom, $urandom, $urandom);
         else
            add_cmd(KIND_STATUS, $urandom, $urandom, ($urandom_range(9) < 8),
                    ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(120));
      end
   endtask

   task automatic wait_idle();
      while (pend_q.size() > 0 || req_valid || rsp_expect_q.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_LOAD_LIMIT) m_limit = val;
      else m_weight = val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   int lim_set [7] = '{1000, 0, 2047, 2047, 400, 60, 1};
   int wgt_set [7] = '{2, 15, 0, 15, 1, 8, 0};

   initial begin
      reset = 1;
      req_valid = 0;
      req_kind = '0;
      req_task_id = '0;
      req_worker = '0;
      req_alive = 0;
      req_load = '0;
      rsp_ready = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      m_head = 0;
      m_tail = 0;
      m_count = 0;
      m_limit = LOAD_LIMIT_RST;
      m_weight = TASK_WEIGHT_RST;
      for (int i = 0; i < NW*NS; i++) begin
         m_slot_vld[i] = 0;
         m_slot_id[i] = '0;
      end
      for (int i = 0; i < NW; i++) begin
         m_wcount[i] = 0;
         m_alive[i] = 0;
         m_load[i] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty queue, dead workers, field extremes, every kind
      add_cmd(KIND_DISPATCH, 16'hffff, 15, 1, 1023);
      add_cmd(KIND_SUBMIT, 0, 0, 0, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_STATUS, 0, 0, 1, 0);
      add_cmd(KIND_STATUS, 0, 15, 1, 1023);
      add_cmd(KIND_SUBMIT, 16'hffff, 15, 1, 1023);
      add_cmd(KIND_SUBMIT, 16'h5a5a, 0, 0, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_STATUS, 0, 7, 1, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_RECOVER, 0, 15, 0, 0);
      add_cmd(KIND_RECOVER, 0, 0, 1, 1023);
      add_cmd(KIND_STATUS, 0, 0, 0, 0);
      add_cmd(KIND_STATUS, 0, 7, 0, 512);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      add_cmd(KIND_DISPATCH, 0, 0, 0, 0);
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         snd_idle_pct = (p == 0) ? 36 : (p == 1) ? 74 : 0;
         rcv_idle_pct = (p == 0) ? 74 : (p == 1) ? 36 : 0;
         for (int s = 0; s < 7; s++) begin
            csr_write(CSR_LOAD_LIMIT, lim_set[(s + p) % 7]);
            csr_write(CSR_TASK_WEIGHT, wgt_set[(s + p) % 7]);
            // bring several workers up, then mix kinds per chunk flavor
            add_random(8, 0, 0, 0);
            case (s % 4)
               0: add_random(80, 35, 35, 10);
               1: add_random(80, 75, 10, 5);
               2: add_random(80, 20, 60, 5);
               default: add_random(80, 45, 25, 20);
            endcase
            if (p == 0 && s == 1) begin
               // long receiver hold while commands keep coming
               hold_seq++;
               add_random(20, 40, 40, 10);
            end
            if (p == 1 && s == 3) begin
               // sender pause until the block has answered everything
               while (pend_q.size() > 0 || req_valid || rsp_expect_q.size() > 0)
                  @(posedge clock);
               add_random(20, 40, 40, 10);
            end
            wait_idle();
         end
      end

      $display("covered %0d commands: %0d placed, %0d requeued, %0d empty pops",
               n_cmd, n_placed, n_requeue, n_empty);
      $display("%0d full-queue drops, %0d tasks recovered", n_drop, n_recov);
      if (err_cnt == 0)
         $display("least_loaded_task_dispatcher_unit_test: done, clean");
      else
         $display("least_loaded_task_dispatcher_unit_test: done, errors");
      $finish;
   end

endmodule
